// File: design/nearest_available_entry_matcher_core_macros.svh
// assertion macros for the matcher rtl
`ifndef NEAREST_AVAILABLE_ENTRY_MATCHER_CORE_MACROS_SVH
`define NEAREST_AVAILABLE_ENTRY_MATCHER_CORE_MACROS_SVH

// same-cycle implication, checked on clk outside reset
`define NAM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk outside reset
`define NAM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/nam_pkg.sv
// shared types and constants for the nearest available entry matcher
`default_nettype none

package nam_pkg;

	localparam int ID_W        = 16;
	localparam int IN_COORD_W  = 16;
	localparam int DIST_W      = 33;
	localparam int ECNT_W      = 3;
	localparam int EXCL_FIELDS = 4;
	localparam int MAX_EXCLUDED = 4;
	localparam int EXCL_LIM    = (MAX_EXCLUDED < EXCL_FIELDS) ? MAX_EXCLUDED : EXCL_FIELDS;

	localparam logic [DIST_W-1:0] DIST_RESET = 33'd9999999;

	typedef enum logic {
		ACT_UPDATE  = 1'b0,
		ACT_REQUEST = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_OFFLINE   = 2'd0,
		ST_AVAILABLE = 2'd1,
		ST_ON_TRIP   = 2'd2,
		ST_BUSY      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR  = 3'd0,
		S_IDLE   = 3'd1,
		S_SCAN   = 3'd2,
		S_FINISH = 3'd3,
		S_DONE   = 3'd4
	} seq_state_t;

	// table write strobes
	typedef struct packed {
		logic status;
		logic data;
	} tbl_wen_t;

	typedef logic [EXCL_FIELDS-1:0][ID_W-1:0] excl_ids_t;

endpackage

`default_nettype wire

// File: design/nam_table.sv
// entry table: status memory and id/coordinate memory, registered read
`default_nettype none

module nam_table #(
	parameter int DEPTH = 64,
	parameter int CW    = 16,
	parameter int AW    = 6
) (
	input  logic                      clk,
	input  nam_pkg::tbl_wen_t         wen,
	input  logic [AW-1:0]             wr_addr,
	input  nam_pkg::status_t          wr_status,
	input  logic [nam_pkg::ID_W-1:0]  wr_id,
	input  logic [CW-1:0]             wr_x,
	input  logic [CW-1:0]             wr_y,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output nam_pkg::status_t          rd_status,
	output logic [nam_pkg::ID_W-1:0]  rd_id,
	output logic [CW-1:0]             rd_x,
	output logic [CW-1:0]             rd_y
);
	import nam_pkg::*;

	localparam int DW = ID_W + 2 * CW;

	status_t         status_mem [DEPTH];
	logic [DW-1:0]   data_mem   [DEPTH];
	status_t         rd_status_q;
	logic [DW-1:0]   rd_data_q;

	always_ff @(posedge clk) begin
		if (wen.status) begin
			status_mem[wr_addr] <= wr_status;
		end
		if (rd_en) begin
			rd_status_q <= status_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wen.data) begin
			data_mem[wr_addr] <= {wr_id, wr_x, wr_y};
		end
		if (rd_en) begin
			rd_data_q <= data_mem[rd_addr];
		end
	end

	assign rd_status = rd_status_q;
	assign rd_id     = rd_data_q[DW-1 -: ID_W];
	assign rd_x      = rd_data_q[2*CW-1 -: CW];
	assign rd_y      = rd_data_q[CW-1:0];

endmodule

`default_nettype wire

// File: design/nam_dist.sv
// pipelined squared-distance and eligibility unit, one entry per cycle
`default_nettype none

module nam_dist #(
	parameter int CW = 16,
	parameter int AW = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_vld,
	input  logic [AW-1:0]                     in_idx,
	input  nam_pkg::status_t                  in_status,
	input  logic [nam_pkg::ID_W-1:0]          in_id,
	input  logic [CW-1:0]                     in_x,
	input  logic [CW-1:0]                     in_y,
	input  logic [CW-1:0]                     req_x,
	input  logic [CW-1:0]                     req_y,
	input  nam_pkg::excl_ids_t                excl_ids,
	input  logic [nam_pkg::EXCL_FIELDS-1:0]   excl_en,
	output logic                              out_vld,
	output logic                              out_elig,
	output logic [AW-1:0]                     out_idx,
	output logic [nam_pkg::ID_W-1:0]          out_id,
	output logic [2*CW:0]                     out_dist,
	output logic                              busy
);
	import nam_pkg::*;

	localparam int SQ_W = 2 * CW;

	logic              hit_excl;
	logic [CW-1:0]     dx_c, dy_c;
	logic              vld_s2, vld_s3;
	logic [CW-1:0]     dx_s2, dy_s2;
	logic              elig_s2, elig_s3;
	logic [AW-1:0]     idx_s2, idx_s3;
	logic [ID_W-1:0]   id_s2, id_s3;
	logic [SQ_W-1:0]   sx_c, sy_c;
	logic [SQ_W-1:0]   sx_s3, sy_s3;

	always_comb begin
		hit_excl = 1'b0;
		for (int j = 0; j < EXCL_FIELDS; j++) begin
			if (excl_en[j] && (in_id == excl_ids[j])) begin
				hit_excl = 1'b1;
			end
		end
	end

	// coordinates are offset binary, so unsigned compare gives signed order
	assign dx_c = (in_x > req_x) ? (in_x - req_x) : (req_x - in_x);
	assign dy_c = (in_y > req_y) ? (in_y - req_y) : (req_y - in_y);

	assign sx_c = SQ_W'(dx_s2) * SQ_W'(dx_s2);
	assign sy_c = SQ_W'(dy_s2) * SQ_W'(dy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= in_vld;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2   <= dx_c;
		dy_s2   <= dy_c;
		elig_s2 <= (in_status == ST_AVAILABLE) && !hit_excl;
		idx_s2  <= in_idx;
		id_s2   <= in_id;
		sx_s3   <= sx_c;
		sy_s3   <= sy_c;
		elig_s3 <= elig_s2;
		idx_s3  <= idx_s2;
		id_s3   <= id_s2;
	end

	assign out_vld  = vld_s3;
	assign out_elig = elig_s3;
	assign out_idx  = idx_s3;
	assign out_id   = id_s3;
	assign out_dist = {1'b0, sx_s3} + {1'b0, sy_s3};
	assign busy     = vld_s2 | vld_s3;

endmodule

`default_nettype wire

// File: design/nearest_available_entry_matcher_core.sv
// top level of the nearest available entry matcher
// usage:
//  - input channel in_valid/in_ready carries one transaction per item: an update
//    (action 0) writes the first slot whose id matches or that is offline, a
//    request (action 1) looks for the nearest available, non-excluded entry
//  - output channel out_valid/out_ready returns one transaction per item:
//    match_found and match_id (both zero for updates and failed requests)
//  - cfg_wr_en/cfg_wr_data write the squared distance bound at once; the user
//    must write it only while idle, which the block itself does not enforce
//  - after reset a clearing pass marks every slot offline, with in_ready low;
//    configuration writes are still taken
//  - a request scans every slot, an update stops at its first hit, and a request
//    with no available entries answers without a scan
//  - the next transaction is taken in the cycle after a result is loaded, and
//    none before that; the single table read port scans one entry a cycle and
//    feeds the shared distance pipeline
//  - a result waits in the output register while the receiver stalls; the next
//    transaction is still accepted and runs until its own result is ready
`default_nettype none
`include "nearest_available_entry_matcher_core_macros.svh"

module nearest_available_entry_matcher_core #(
	parameter int TABLE_DEPTH = 64,
	parameter int COORD_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [nam_pkg::DIST_W-1:0]            cfg_wr_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  action,
	input  logic [nam_pkg::ID_W-1:0]              entry_id,
	input  logic [1:0]                            new_status,
	input  logic signed [nam_pkg::IN_COORD_W-1:0] pos_x,
	input  logic signed [nam_pkg::IN_COORD_W-1:0] pos_y,
	input  logic [nam_pkg::ECNT_W-1:0]            excl_count,
	input  logic [nam_pkg::ID_W-1:0]              exclude_id_0,
	input  logic [nam_pkg::ID_W-1:0]              exclude_id_1,
	input  logic [nam_pkg::ID_W-1:0]              exclude_id_2,
	input  logic [nam_pkg::ID_W-1:0]              exclude_id_3,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  match_found,
	output logic [nam_pkg::ID_W-1:0]              match_id
);
	import nam_pkg::*;

	localparam int CW     = COORD_WIDTH;
	localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int SUM_W  = 2 * CW + 1;
	localparam int CMP_W  = (SUM_W > DIST_W) ? SUM_W : DIST_W;
	localparam logic [AW-1:0]    LAST_ADDR = AW'(TABLE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(TABLE_DEPTH);
	localparam logic [CW-1:0]    SIGN_FLIP = {1'b1, {(CW-1){1'b0}}};
	localparam logic [ECNT_W-1:0] ECNT_LIM = ECNT_W'(EXCL_LIM);

	// sequencer and control state
	seq_state_t          state_q, state_d;
	logic [AW-1:0]       addr_q;
	logic                issue_q;
	logic                vld_s1;
	logic [AW-1:0]       idx_s1;
	logic [CNT_W-1:0]    cnt_q;
	logic [DIST_W-1:0]   max_dist_sq_q;
	logic                found_q;
	logic                out_valid_q;

	// item and search payload
	action_t             act_q;
	logic [ID_W-1:0]     id_q;
	status_t             st_q;
	logic [CW-1:0]       px_q, py_q;
	excl_ids_t           excl_ids_q;
	logic [EXCL_FIELDS-1:0] excl_en_q;
	logic [DIST_W-1:0]   best_q;
	logic [AW-1:0]       best_idx_q;
	logic [ID_W-1:0]     best_id_q;
	logic                res_found_q;
	logic [ID_W-1:0]     res_id_q;
	logic                match_found_q;
	logic [ID_W-1:0]     match_id_q;

	// combinational control
	logic                in_fire;
	logic                req_in;
	logic                cnt_zero;
	logic                rd_en;
	tbl_wen_t            wen;
	logic [AW-1:0]       wr_addr;
	status_t             wr_status;
	logic                load_out;
	logic                upd_hit;
	logic                scan_empty;
	logic                best_upd;
	logic [ECNT_W-1:0]   ecnt_c;
	logic [EXCL_FIELDS-1:0] excl_en_c;
	logic [CW-1:0]       px_c, py_c;

	// table read side
	status_t             rd_status;
	logic [ID_W-1:0]     rd_id;
	logic [CW-1:0]       rd_x, rd_y;

	// distance unit outputs
	logic                dist_in_vld;
	logic                dist_vld;
	logic                dist_elig;
	logic [AW-1:0]       dist_idx;
	logic [ID_W-1:0]     dist_id;
	logic [SUM_W-1:0]    dist_sum;
	logic                dist_busy;

	assign in_fire  = in_valid && in_ready;
	assign req_in   = (action == ACT_REQUEST);
	assign cnt_zero = (cnt_q == '0);

	// coordinates held as offset binary of their low COORD_WIDTH bits
	assign px_c = CW'($unsigned(pos_x)) ^ SIGN_FLIP;
	assign py_c = CW'($unsigned(pos_y)) ^ SIGN_FLIP;

	// exclude count clamped to the usable fields
	assign ecnt_c = (excl_count > ECNT_LIM) ? ECNT_LIM : excl_count;
	always_comb begin
		for (int j = 0; j < EXCL_FIELDS; j++) begin
			excl_en_c[j] = (ECNT_W'(j) < ecnt_c);
		end
	end

	// an update stops at the first slot with its id or an offline slot
	assign upd_hit = (act_q == ACT_UPDATE) && vld_s1
	               && ((rd_id == id_q) || (rd_status == ST_OFFLINE));

	assign scan_empty = !issue_q && !vld_s1 && !dist_busy;

	assign dist_in_vld = vld_s1 && (act_q == ACT_REQUEST) && (state_q == S_SCAN);

	// strictly below the current best, which starts at the bound
	assign best_upd = (state_q == S_SCAN) && dist_vld && dist_elig
	                && (CMP_W'(dist_sum) < CMP_W'(best_q));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (addr_q == LAST_ADDR) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = (req_in && cnt_zero) ? S_DONE : S_SCAN;
				end
			end
			S_SCAN: begin
				if (upd_hit) begin
					state_d = S_DONE;
				end else if (scan_empty) begin
					state_d = (act_q == ACT_REQUEST) ? S_FINISH : S_DONE;
				end
			end
			S_FINISH: state_d = S_DONE;
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		rd_en     = 1'b0;
		wen       = '0;
		wr_addr   = idx_s1;
		wr_status = st_q;
		load_out  = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				wen.status = 1'b1;
				wr_addr    = addr_q;
				wr_status  = ST_OFFLINE;
			end
			S_IDLE: in_ready = 1'b1;
			S_SCAN: begin
				rd_en = issue_q;
				if (upd_hit) begin
					wen.status = 1'b1;
					wen.data   = 1'b1;
				end
			end
			S_FINISH: begin
				if (found_q) begin
					wen.status = 1'b1;
					wr_addr    = best_idx_q;
					wr_status  = ST_ON_TRIP;
				end
			end
			S_DONE: load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			addr_q        <= '0;
			issue_q       <= 1'b0;
			vld_s1        <= 1'b0;
			cnt_q         <= '0;
			max_dist_sq_q <= DIST_RESET;
			found_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_en;

			if (cfg_wr_en) begin
				max_dist_sq_q <= cfg_wr_data;
			end

			// address walk for the clearing pass and the scans
			if (state_q == S_CLEAR) begin
				addr_q <= (addr_q == LAST_ADDR) ? '0 : addr_q + 1'b1;
			end else if (in_fire) begin
				addr_q <= '0;
			end else if (rd_en && (addr_q != LAST_ADDR)) begin
				addr_q <= addr_q + 1'b1;
			end

			if (in_fire) begin
				issue_q <= !(req_in && cnt_zero);
			end else if (upd_hit || (rd_en && (addr_q == LAST_ADDR))) begin
				issue_q <= 1'b0;
			end

			if (in_fire) begin
				found_q <= 1'b0;
			end else if (best_upd) begin
				found_q <= 1'b1;
			end

			// available count: one change at most per cycle
			if (in_fire && req_in && !cnt_zero) begin
				cnt_q <= cnt_q - 1'b1;
			end else if (state_q == S_SCAN && upd_hit) begin
				if (rd_status != ST_AVAILABLE && st_q == ST_AVAILABLE) begin
					if (cnt_q < CNT_MAX) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end else if (rd_status == ST_AVAILABLE && st_q != ST_AVAILABLE) begin
					if (!cnt_zero) begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
			end else if (state_q == S_FINISH && !found_q) begin
				// nothing matched, the count goes back
				if (cnt_q < CNT_MAX) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		if (in_fire) begin
			act_q       <= action_t'(action);
			id_q        <= entry_id;
			st_q        <= status_t'(new_status);
			px_q        <= px_c;
			py_q        <= py_c;
			excl_ids_q  <= {exclude_id_3, exclude_id_2, exclude_id_1, exclude_id_0};
			excl_en_q   <= excl_en_c;
			best_q      <= max_dist_sq_q;
			res_found_q <= 1'b0;
			res_id_q    <= '0;
		end
		if (best_upd) begin
			best_q     <= DIST_W'(dist_sum);
			best_idx_q <= dist_idx;
			best_id_q  <= dist_id;
		end
		if (state_q == S_FINISH) begin
			res_found_q <= found_q;
			res_id_q    <= found_q ? best_id_q : '0;
		end
		if (load_out) begin
			match_found_q <= res_found_q;
			match_id_q    <= res_id_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign match_found = match_found_q;
	assign match_id    = match_id_q;

	nam_table #(
		.DEPTH (TABLE_DEPTH),
		.CW    (CW),
		.AW    (AW)
	) u_table (
		.clk       (clk),
		.wen       (wen),
		.wr_addr   (wr_addr),
		.wr_status (wr_status),
		.wr_id     (id_q),
		.wr_x      (px_q),
		.wr_y      (py_q),
		.rd_en     (rd_en),
		.rd_addr   (addr_q),
		.rd_status (rd_status),
		.rd_id     (rd_id),
		.rd_x      (rd_x),
		.rd_y      (rd_y)
	);

	nam_dist #(
		.CW (CW),
		.AW (AW)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (dist_in_vld),
		.in_idx    (idx_s1),
		.in_status (rd_status),
		.in_id     (rd_id),
		.in_x      (rd_x),
		.in_y      (rd_y),
		.req_x     (px_q),
		.req_y     (py_q),
		.excl_ids  (excl_ids_q),
		.excl_en   (excl_en_q),
		.out_vld   (dist_vld),
		.out_elig  (dist_elig),
		.out_idx   (dist_idx),
		.out_id    (dist_id),
		.out_dist  (dist_sum),
		.busy      (dist_busy)
	);

	// count stays within the table depth
	`NAM_ASSERT_SAME(a_cnt_range, 1'b1, cnt_q <= CNT_MAX, "available count above table depth")

	// a request with nothing available answers without a scan
	`NAM_ASSERT_NEXT(a_req_empty, in_fire && req_in && cnt_zero, state_q == S_DONE && !issue_q, "empty request started a scan")

	// a request that goes on to scan takes one count
	`NAM_ASSERT_NEXT(a_req_take, in_fire && req_in && !cnt_zero, cnt_q == $past(cnt_q) - 1'b1, "request did not take a count")

	// the table is only written by the clearing pass, a scan or the finish step
	`NAM_ASSERT_SAME(a_no_idle_wr, state_q == S_IDLE || state_q == S_DONE, !wen.status && !wen.data, "table written outside a scan")

	// a chosen entry beats the bound
	`NAM_ASSERT_SAME(a_best_bound, state_q == S_FINISH && found_q, best_q < max_dist_sq_q, "match not below the distance bound")

endmodule

`default_nettype wire

// File: tb/nearest_available_entry_matcher_core_test.sv
// self-checking testbench for the nearest available entry matcher core
`timescale 1ns / 100ps

module nearest_available_entry_matcher_core_test;
	import nam_pkg::*;

	localparam int TBL_DEPTH = 64;
	localparam int POOL_SIZE = 48;
	localparam int FULL_SPREAD = 32768;

	// one input transaction, field for field as the ports carry it
	typedef struct packed {
		action_t            act;
		logic [ID_W-1:0]    id;
		status_t            st;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [ECNT_W-1:0]  ecnt;
		excl_ids_t          excl;
	} matcher_item_t;

	// one output transaction
	typedef struct packed {
		logic            found;
		logic [ID_W-1:0] id;
	} match_t;

	// a line of the directed script: either a bound write or an item
	typedef struct packed {
		bit            is_cfg;
		logic [DIST_W-1:0] bound;
		matcher_item_t item;
		bit            known;
		match_t        typed_match;
	} script_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [DIST_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = 1'b0;
	logic [ID_W-1:0] entry_id = '0;
	logic [1:0] new_status = '0;
	logic signed [IN_COORD_W-1:0] pos_x = '0;
	logic signed [IN_COORD_W-1:0] pos_y = '0;
	logic [ECNT_W-1:0] excl_count = '0;
	logic [ID_W-1:0] exclude_id_0 = '0;
	logic [ID_W-1:0] exclude_id_1 = '0;
	logic [ID_W-1:0] exclude_id_2 = '0;
	logic [ID_W-1:0] exclude_id_3 = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic match_found;
	logic [ID_W-1:0] match_id;

	// predictor's own copy of the table, the counter and the bound
	logic [ID_W-1:0]    tbl_id [TBL_DEPTH];
	status_t            tbl_st [TBL_DEPTH];
	logic signed [15:0] tbl_x  [TBL_DEPTH];
	logic signed [15:0] tbl_y  [TBL_DEPTH];
	int unsigned        avail_entries;
	logic [DIST_W-1:0]  dist_bound;

	match_t        expected_matches[$];
	script_row_t   script[$];
	logic [ID_W-1:0] id_pool [POOL_SIZE];
	bit            quiet = 1'b0;
	int            err_count = 0;

	nearest_available_entry_matcher_core #(
		.TABLE_DEPTH(TBL_DEPTH),
		.COORD_WIDTH(16)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.entry_id(entry_id),
		.new_status(new_status),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.excl_count(excl_count),
		.exclude_id_0(exclude_id_0),
		.exclude_id_1(exclude_id_1),
		.exclude_id_2(exclude_id_2),
		.exclude_id_3(exclude_id_3),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.match_found(match_found),
		.match_id(match_id)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop, far beyond the slowest legal run
	initial begin
		#1_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic flag_error(input string what);
		err_count++;
		if (err_count <= 10)
			$display("mismatch: %s", what);
	endtask

	// works out the answer to one accepted transaction and moves the table on
	function automatic match_t predict_match(input matcher_item_t it);
		match_t res;
		bit hit, excluded, found;
		status_t old;
		int lim, best_i, ax, ay;
		longint unsigned dx, dy, sq_sum, best;
		res = '0;
		if (it.act == ACT_UPDATE) begin
			// first slot with the same id or an offline one, otherwise dropped
			hit = 1'b0;
			for (int i = 0; i < TBL_DEPTH; i++) begin
				if (!hit && (tbl_id[i] == it.id || tbl_st[i] == ST_OFFLINE)) begin
					hit = 1'b1;
					old = tbl_st[i];
					tbl_id[i] = it.id;
					tbl_st[i] = it.st;
					tbl_x[i] = it.x;
					tbl_y[i] = it.y;
					if (old != ST_AVAILABLE && it.st == ST_AVAILABLE) begin
						if (avail_entries < TBL_DEPTH)
							avail_entries++;
					end else if (old == ST_AVAILABLE && it.st != ST_AVAILABLE) begin
						if (avail_entries > 0)
							avail_entries--;
					end
				end
			end
			return res;
		end
		// request: nothing available means an immediate miss
		if (avail_entries == 0)
			return res;
		avail_entries--;
		lim = int'(it.ecnt);
		if (lim > EXCL_LIM)
			lim = EXCL_LIM;
		best = 64'(dist_bound);
		best_i = 0;
		found = 1'b0;
		for (int i = 0; i < TBL_DEPTH; i++) begin
			if (tbl_st[i] == ST_AVAILABLE) begin
				excluded = 1'b0;
				for (int j = 0; j < lim; j++)
					if (tbl_id[i] == it.excl[j])
						excluded = 1'b1;
				if (!excluded) begin
					ax = int'(tbl_x[i]) - int'(it.x);
					ay = int'(tbl_y[i]) - int'(it.y);
					if (ax < 0)
						ax = -ax;
					if (ay < 0)
						ay = -ay;
					dx = 64'(ax);
					dy = 64'(ay);
					sq_sum = dx * dx + dy * dy;
					// strict compare keeps the lowest index on a tie
					if (sq_sum < best) begin
						best = sq_sum;
						best_i = i;
						found = 1'b1;
					end
				end
			end
		end
		if (found) begin
			tbl_st[best_i] = ST_ON_TRIP;
			res.found = 1'b1;
			res.id = tbl_id[best_i];
		end else if (avail_entries < TBL_DEPTH) begin
			// no match: the count taken is handed back
			avail_entries++;
		end
		return res;
	endfunction

	function automatic matcher_item_t make_update(input logic [ID_W-1:0] id, input status_t st,
			input logic signed [15:0] x, input logic signed [15:0] y);
		matcher_item_t it;
		it = '0;
		it.act = ACT_UPDATE;
		it.id = id;
		it.st = st;
		it.x = x;
		it.y = y;
		return it;
	endfunction

	function automatic matcher_item_t make_request(input logic signed [15:0] x,
			input logic signed [15:0] y, input int ecnt, input logic [ID_W-1:0] e0,
			input logic [ID_W-1:0] e1, input logic [ID_W-1:0] e2, input logic [ID_W-1:0] e3);
		matcher_item_t it;
		it = '0;
		it.act = ACT_REQUEST;
		it.x = x;
		it.y = y;
		it.ecnt = ecnt[ECNT_W-1:0];
		it.excl[0] = e0;
		it.excl[1] = e1;
		it.excl[2] = e2;
		it.excl[3] = e3;
		return it;
	endfunction

	function automatic void script_item(input matcher_item_t it, input bit known,
			input logic found, input logic [ID_W-1:0] id);
		script_row_t r;
		r = '0;
		r.item = it;
		r.known = known;
		r.typed_match.found = found;
		r.typed_match.id = id;
		script.push_back(r);
	endfunction

	function automatic void script_bound(input logic [DIST_W-1:0] bound);
		script_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.bound = bound;
		script.push_back(r);
	endfunction

	// coordinate near a centre, now and then anywhere in range
	function automatic logic signed [15:0] rand_coord(input int centre, input int spread);
		int v;
		if (spread >= FULL_SPREAD || $urandom_range(0, 9) == 0)
			return 16'($urandom);
		v = centre + int'($urandom_range(0, 2 * spread)) - spread;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return 16'(v);
	endfunction

	function automatic logic [ID_W-1:0] pick_id();
		if ($urandom_range(0, 9) < 8)
			return id_pool[$urandom_range(0, POOL_SIZE - 1)];
		return 16'($urandom);
	endfunction

	function automatic matcher_item_t random_item(input int cx, input int cy, input int spread);
		matcher_item_t it;
		int roll;
		// unused fields carry noise so that the block has to ignore them
		it.id = 16'($urandom);
		it.st = status_t'($urandom_range(0, 3));
		it.ecnt = 3'($urandom_range(0, 7));
		for (int j = 0; j < EXCL_FIELDS; j++)
			it.excl[j] = ($urandom_range(0, 9) < 7) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
				: 16'($urandom);
		it.x = rand_coord(cx, spread);
		it.y = rand_coord(cy, spread);
		if ($urandom_range(0, 99) < 35) begin
			it.act = ACT_REQUEST;
		end else begin
			it.act = ACT_UPDATE;
			it.id = pick_id();
			roll = $urandom_range(0, 99);
			// lean towards available so that requests find something
			if (roll < 50)
				it.st = ST_AVAILABLE;
			else if (roll < 70)
				it.st = ST_OFFLINE;
			else if (roll < 85)
				it.st = ST_ON_TRIP;
			else
				it.st = ST_BUSY;
		end
		return it;
	endfunction

	// drives one transaction and records what should come back for it
	task automatic send_item(input matcher_item_t it, input bit known, input match_t typed);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= it.act;
		entry_id <= it.id;
		new_status <= it.st;
		pos_x <= it.x;
		pos_y <= it.y;
		excl_count <= it.ecnt;
		exclude_id_0 <= it.excl[0];
		exclude_id_1 <= it.excl[1];
		exclude_id_2 <= it.excl[2];
		exclude_id_3 <= it.excl[3];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// accepted at this edge; the predictor always runs to keep its table in step
		typed = known ? typed : predict_match(it);
		if (known)
			void'(predict_match(it));
		expected_matches.push_back(typed);
	endtask

	// bound writes only once every outstanding transaction has answered
	task automatic write_bound(input logic [DIST_W-1:0] bound);
		in_valid <= 1'b0;
		while (expected_matches.size() != 0)
			@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= bound;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		dist_bound = bound;
	endtask

	task automatic run_phase(input logic [DIST_W-1:0] bound, input int spread, input int count,
			input bit fill, input bit calm);
		int cx, cy;
		write_bound(bound);
		quiet = calm;
		cx = int'($urandom_range(0, 60000)) - 30000;
		cy = int'($urandom_range(0, 60000)) - 30000;
		if (fill) begin
			// bring known ids back to available, then flood with fresh ids
			// until the table is full and further updates find no slot
			for (int k = 0; k < POOL_SIZE / 2; k++)
				send_item(make_update(id_pool[k], ST_AVAILABLE, rand_coord(cx, spread),
					rand_coord(cy, spread)), 1'b0, '0);
			repeat (50)
				send_item(make_update(16'($urandom), ST_AVAILABLE, rand_coord(cx, spread),
					rand_coord(cy, spread)), 1'b0, '0);
		end
		repeat (count)
			send_item(random_item(cx, cy, spread), 1'b0, '0);
	endtask

	// receiving side: random back-pressure and in-order checking
	initial begin
		int stall;
		match_t want;
		// outputs are only sampled once reset is released
		wait (arst_n === 1'b1);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			if (expected_matches.size() == 0) begin
				flag_error($sformatf("unexpected transaction found=%0b id=%h",
					match_found, match_id));
			end else begin
				want = expected_matches.pop_front();
				if (match_found !== want.found || match_id !== want.id)
					flag_error($sformatf("found exp %0b got %0b, id exp %h got %h",
						want.found, match_found, want.id, match_id));
			end
		end
	end

	initial begin
		// predictor state as after reset
		for (int i = 0; i < TBL_DEPTH; i++) begin
			tbl_id[i] = '0;
			tbl_st[i] = ST_OFFLINE;
			tbl_x[i] = '0;
			tbl_y[i] = '0;
		end
		avail_entries = 0;
		dist_bound = DIST_RESET;
		foreach (id_pool[k])
			id_pool[k] = 16'($urandom);

		// directed script, bound left at its reset value until stated
		// empty table: a request misses at once
		script_item(make_request(0, 0, 0, 0, 0, 0, 0), 1'b1, 1'b0, 16'h0000);
		script_item(make_update(16'h0000, ST_AVAILABLE, 0, 0), 1'b1, 1'b0, 16'h0000);
		script_item(make_update(16'hFFFF, ST_AVAILABLE, 32767, 32767), 1'b1, 1'b0, 16'h0000);
		script_item(make_update(16'h1234, ST_BUSY, -32768, -32768), 1'b1, 1'b0, 16'h0000);
		// exact hits at the origin and a corner, then the counter is used up
		script_item(make_request(0, 0, 0, 0, 0, 0, 0), 1'b1, 1'b1, 16'h0000);
		script_item(make_request(32767, 32767, 0, 0, 0, 0, 0), 1'b1, 1'b1, 16'hFFFF);
		script_item(make_request(0, 0, 0, 0, 0, 0, 0), 1'b1, 1'b0, 16'h0000);
		// same id rewrites its own slot; equal distances go to the lower slot
		script_item(make_update(16'h0000, ST_AVAILABLE, 10, 0), 1'b0, 1'b0, 16'h0000);
		script_item(make_update(16'hFFFF, ST_AVAILABLE, -10, 0), 1'b0, 1'b0, 16'h0000);
		script_item(make_request(0, 0, 0, 0, 0, 0, 0), 1'b1, 1'b1, 16'h0000);
		script_item(make_update(16'h0000, ST_AVAILABLE, 10, 0), 1'b0, 1'b0, 16'h0000);
		script_item(make_request(0, 0, 1, 16'h0000, 0, 0, 0), 1'b1, 1'b1, 16'hFFFF);
		script_item(make_update(16'hFFFF, ST_AVAILABLE, -10, 0), 1'b0, 1'b0, 16'h0000);
		// oversized exclude count is clamped, everything excluded means a miss
		script_item(make_request(0, 0, 7, 16'h0000, 16'hFFFF, 16'h1111, 16'h2222),
			1'b1, 1'b0, 16'h0000);
		script_item(make_request(0, 0, 4, 16'hFFFF, 16'h1111, 16'h2222, 16'h0000),
			1'b1, 1'b0, 16'h0000);
		// ids beyond the exclude count do not apply
		script_item(make_request(0, 0, 2, 16'hFFFF, 16'h5555, 16'h0000, 16'h0000),
			1'b1, 1'b1, 16'h0000);
		script_item(make_update(16'hFFFF, ST_OFFLINE, 0, 0), 1'b1, 1'b0, 16'h0000);
		script_item(make_request(0, 0, 0, 0, 0, 0, 0), 1'b1, 1'b0, 16'h0000);
		// offline slot gets reused by a new id
		script_item(make_update(16'h00FF, ST_ON_TRIP, -32768, 32767), 1'b1, 1'b0, 16'h0000);
		script_item(make_update(16'h00FF, ST_AVAILABLE, 100, 100), 1'b0, 1'b0, 16'h0000);
		// too far away under the reset bound
		script_item(make_request(-32768, -32768, 0, 0, 0, 0, 0), 1'b1, 1'b0, 16'h0000);
		// distance equal to the bound misses, one below it hits
		script_bound(33'd100);
		script_item(make_request(90, 100, 0, 0, 0, 0, 0), 1'b1, 1'b0, 16'h0000);
		script_bound(33'd101);
		script_item(make_request(90, 100, 0, 0, 0, 0, 0), 1'b1, 1'b1, 16'h00FF);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[r]) begin
			if (script[r].is_cfg)
				write_bound(script[r].bound);
			else
				send_item(script[r].item, script[r].known, script[r].typed_match);
		end

		// random phases, each opened by a bound write on an idle block
		run_phase(DIST_RESET, 2000, 50, 1'b0, 1'b0);
		run_phase(33'h1_FFFF_FFFF, FULL_SPREAD, 50, 1'b0, 1'b0);
		run_phase(33'd0, 3, 30, 1'b0, 1'b1);
		run_phase(33'd20, 3, 12, 1'b1, 1'b0);
		run_phase({1'($urandom_range(0, 1)), 32'($urandom)}, FULL_SPREAD, 40, 1'b0, 1'b1);
		run_phase(33'd10000, 50, 50, 1'b0, 1'b0);
		run_phase(DIST_RESET, 2000, 50, 1'b0, 1'b1);
		run_phase(33'd2000000, 2000, 50, 1'b0, 1'b0);
		run_phase(33'd1, 2, 40, 1'b0, 0);

		in_valid <= 1'b0;
		while (expected_matches.size() != 0)
			@(posedge clk);
		// room for any stray transaction after the last one due
		repeat (80) @(posedge clk);
		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
